@@ rtl/tlvnsi_pkg.sv @@
package tlvnsi_pkg;

  localparam int unsigned MaxNameBytesDefault = 65536;
  localparam int unsigned HdrBytes = 4;
  localparam logic [2:0] HdrPayload = 3'd4;
  localparam logic [14:0] SegSatMax = 15'h7FFF;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusTruncated = 2'd1,
    StatusOverflow  = 2'd2
  } parse_status_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       is_last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [15:0]   segment_offset;
    logic [15:0]   segment_size;
    logic [13:0]   segment_index;
    logic          segment_valid;
    logic          end_of_name;
    logic [14:0]   segment_count;
    parse_status_e parse_status;
  } out_beat_t;

endpackage

@@ rtl/tlv_name_segment_indexer_top.sv @@
// TLV name segment indexer.
// The input channel carries one byte of a name's wire format per beat, with
// a flag on the final byte. Each component opens with a four-byte header
// whose bytes 2 and 3 give the payload length, big-endian.
// The output channel carries one beat when a component completes, or on the
// final byte of a name, giving offset, size, index, the component count and
// a parse status. Other bytes produce no output beat.
// One byte is accepted per cycle while the input does not stall; the result
// appears in the cycle after the byte is accepted, from the output register.
// The parser state and the output register are the only storage, so the
// rate is set by the single state update per byte.
// When the receiver stalls, the output beat holds. A new byte is accepted
// while the output register is empty or its beat is taken in that cycle, so
// the input stalls, whatever the byte, only while a held output beat is not
// taken in that cycle.
// Reset clears the parser state and empties the output register. After the
// final byte of a name the parser returns to its reset state.
module tlv_name_segment_indexer_top
  import tlvnsi_pkg::*;
#(
  parameter int unsigned MAX_NAME_BYTES = MaxNameBytesDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  localparam int unsigned PosW = $clog2(MAX_NAME_BYTES + 1);

  logic [PosW-1:0] pos_q, pos_d;
  logic [2:0]      hdr_q, hdr_d;
  logic [7:0]      len_hi_q, len_hi_d;
  logic [15:0]     rem_q, rem_d;
  logic [15:0]     start_q, start_d;
  logic [15:0]     size_q, size_d;
  logic [14:0]     seen_q, seen_d;
  logic            ovf_q, ovf_d;

  logic            out_valid_q;
  out_beat_t       out_beat_q, out_beat_d;

  logic            in_acc;
  logic            done;
  logic            emit;
  logic [15:0]     rem_dec;
  logic [31:0]     pos_ext;
  logic [14:0]     seen_dec;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pos_ext    = 32'(pos_q);
  assign rem_dec    = rem_q - 16'd1;

  always_comb begin
    pos_d    = pos_q;
    hdr_d    = hdr_q;
    len_hi_d = len_hi_q;
    rem_d    = rem_q;
    start_d  = start_q;
    size_d   = size_q;
    seen_d   = seen_q;
    ovf_d    = ovf_q;
    done     = 1'b0;
    if (pos_ext >= 32'(MAX_NAME_BYTES)) begin
      ovf_d = 1'b1;
    end else begin
      if (hdr_q != HdrPayload) begin
        if (hdr_q == 3'd0) begin
          start_d = pos_ext[15:0];
          if (seen_q < SegSatMax) begin
            seen_d = seen_q + 15'd1;
          end
        end
        if (hdr_q == 3'd2) begin
          len_hi_d = in_beat_i.byte_value;
        end
        if (hdr_q == 3'(HdrBytes - 1)) begin
          size_d = {len_hi_q, in_beat_i.byte_value};
          if (size_d == 16'd0) begin
            done  = 1'b1;
            hdr_d = 3'd0;
          end else begin
            rem_d = size_d;
            hdr_d = HdrPayload;
          end
        end else begin
          hdr_d = hdr_q + 3'd1;
        end
      end else begin
        rem_d = rem_dec;
        if (rem_dec == 16'd0) begin
          done  = 1'b1;
          hdr_d = 3'd0;
        end
      end
      pos_d = pos_q + PosW'(1);
    end
  end

  assign emit     = done || in_beat_i.is_last_byte;
  assign seen_dec = seen_d - 15'd1;

  always_comb begin
    out_beat_d.segment_offset = done ? start_d : 16'd0;
    out_beat_d.segment_size   = done ? size_d : 16'd0;
    out_beat_d.segment_index  = done ? seen_dec[13:0] : 14'd0;
    out_beat_d.segment_valid  = done;
    out_beat_d.end_of_name    = in_beat_i.is_last_byte;
    out_beat_d.segment_count  = seen_d;
    out_beat_d.parse_status   = StatusOk;
    if (in_beat_i.is_last_byte) begin
      if (ovf_d) begin
        out_beat_d.parse_status = StatusOverflow;
      end else if (hdr_d != 3'd0) begin
        out_beat_d.parse_status = StatusTruncated;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      hdr_q    <= '0;
      len_hi_q <= '0;
      rem_q    <= '0;
      start_q  <= '0;
      size_q   <= '0;
      seen_q   <= '0;
      ovf_q    <= 1'b0;
    end else if (in_acc) begin
      if (in_beat_i.is_last_byte) begin
        pos_q    <= '0;
        hdr_q    <= '0;
        len_hi_q <= '0;
        rem_q    <= '0;
        start_q  <= '0;
        size_q   <= '0;
        seen_q   <= '0;
        ovf_q    <= 1'b0;
      end else begin
        pos_q    <= pos_d;
        hdr_q    <= hdr_d;
        len_hi_q <= len_hi_d;
        rem_q    <= rem_d;
        start_q  <= start_d;
        size_q   <= size_d;
        seen_q   <= seen_d;
        ovf_q    <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      out_beat_q <= out_beat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  a_hdr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_q <= HdrPayload)
    else $error("header byte count out of range");

  a_seg_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.segment_valid |-> out_beat_o.segment_count != 15'd0)
    else $error("completed segment with zero count");

  a_status_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_beat_o.end_of_name |-> out_beat_o.parse_status == StatusOk)
    else $error("status reported before end of name");

  a_name_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_beat_i.is_last_byte |=> pos_q == '0 && seen_q == '0 && hdr_q == '0)
    else $error("parser not restarted after final byte");

endmodule

@@ tb/sv/tlv_name_segment_indexer_top_test.sv @@
module tlv_name_segment_indexer_top_test
  import tlvnsi_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] name_bytes_t[$];

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_beat_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_beat_o;

  int unsigned idle_pct = 32;
  int unsigned rx_hold_left = 0;
  int unsigned mismatches = 0;
  out_beat_t   pending_reports[$];

  logic [16:0] name_pos;
  logic [2:0]  hdr_cnt;
  logic [7:0]  len_hi;
  logic [15:0] pay_left;
  logic [15:0] seg_start;
  logic [15:0] seg_size;
  logic [14:0] seg_seen;
  logic        name_overflow;

  tlv_name_segment_indexer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic restart_name();
    name_pos      = '0;
    hdr_cnt       = '0;
    len_hi        = '0;
    pay_left      = '0;
    seg_start     = '0;
    seg_size      = '0;
    seg_seen      = '0;
    name_overflow = 1'b0;
  endtask

  task automatic index_byte(input in_beat_t beat);
    out_beat_t   rpt;
    logic        done;
    logic [14:0] idx;
    done = 1'b0;
    if (name_pos >= MaxNameBytesDefault) begin
      name_overflow = 1'b1;
    end else begin
      if (hdr_cnt < HdrBytes) begin
        if (hdr_cnt == 3'd0) begin
          seg_start = name_pos[15:0];
          if (seg_seen < SegSatMax) begin
            seg_seen = seg_seen + 15'd1;
          end
        end
        if (hdr_cnt == 3'd2) begin
          len_hi = beat.byte_value;
        end
        if (hdr_cnt == 3'd3) begin
          seg_size = {len_hi, beat.byte_value};
          if (seg_size == 16'd0) begin
            done    = 1'b1;
            hdr_cnt = '0;
          end else begin
            pay_left = seg_size;
            hdr_cnt  = HdrPayload;
          end
        end else begin
          hdr_cnt = hdr_cnt + 3'd1;
        end
      end else begin
        pay_left = pay_left - 16'd1;
        if (pay_left == 16'd0) begin
          done    = 1'b1;
          hdr_cnt = '0;
        end
      end
      name_pos = name_pos + 17'd1;
    end
    if (done || beat.is_last_byte) begin
      rpt = '0;
      if (done) begin
        idx                = seg_seen - 15'd1;
        rpt.segment_offset = seg_start;
        rpt.segment_size   = seg_size;
        rpt.segment_index  = idx[13:0];
        rpt.segment_valid  = 1'b1;
      end
      rpt.end_of_name   = beat.is_last_byte;
      rpt.segment_count = seg_seen;
      rpt.parse_status  = StatusOk;
      if (beat.is_last_byte) begin
        if (name_overflow) begin
          rpt.parse_status = StatusOverflow;
        end else if (hdr_cnt != 3'd0) begin
          rpt.parse_status = StatusTruncated;
        end
      end
      pending_reports.push_back(rpt);
    end
    if (beat.is_last_byte) begin
      restart_name();
    end
  endtask

  // Valid stays high after a beat is taken; the next call either drives the
  // next beat or first lowers it for idle cycles.
  task automatic send_byte(input logic [7:0] value, input logic last);
    in_beat_t beat;
    beat.byte_value   = value;
    beat.is_last_byte = last;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= beat;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    index_byte(beat);
  endtask

  task automatic send_name(input name_bytes_t name);
    foreach (name[k]) begin
      send_byte(name[k], k == name.size() - 1);
    end
  endtask

  function automatic void add_segment(ref name_bytes_t name, input logic [15:0] len);
    name.push_back(8'($urandom_range(255)));
    name.push_back(8'($urandom_range(255)));
    name.push_back(len[15:8]);
    name.push_back(len[7:0]);
    for (int unsigned k = 0; k < len; k++) begin
      name.push_back(8'($urandom_range(255)));
    end
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic test_directed();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_byte_bound();
    name_bytes_t name;
    idle_pct = 0;
    name = {};
    add_segment(name, 16'hFFF7);
    add_segment(name, 16'h0000);
    repeat (3) begin
      name.push_back(8'($urandom_range(255)));
    end
    send_name(name);
    name = {};
    repeat (16384) begin
      add_segment(name, 16'h0000);
    end
    send_name(name);
    idle_pct = 32;
  endtask

  task automatic test_output_hold();
    name_bytes_t name;
    rx_hold_left = 300;
    repeat (12) begin
      name = {};
      add_segment(name, 16'h0000);
      send_name(name);
    end
    wait_drained();
    repeat (6) begin
      name = {};
      add_segment(name, 16'd3);
      send_name(name);
    end
    wait_drained();
  endtask

  task automatic test_random_names();
    name_bytes_t name;
    int unsigned sent;
    int unsigned kind;
    int unsigned cut;
    logic [15:0] len;
    sent = 0;
    while (sent < 900) begin
      name = {};
      kind = $urandom_range(99);
      if (kind < 10) begin
        repeat ($urandom_range(12, 1)) begin
          name.push_back(8'($urandom_range(255)));
        end
      end else begin
        repeat ($urandom_range(5, 1)) begin
          len = ($urandom_range(9) == 0) ? 16'($urandom_range(40)) : 16'($urandom_range(6));
          add_segment(name, len);
        end
        if (kind < 25) begin
          cut  = $urandom_range(name.size() - 1, 1);
          name = name[0:cut-1];
        end
      end
      send_name(name);
      sent += name.size();
    end
  endtask

  function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rx_hold_left > 0) begin
      out_stall_i  <= 1'b1;
      rx_hold_left = rx_hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        $error("output beat with no result expected");
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("segment_offset", want.segment_offset, out_beat_o.segment_offset);
        check_field("segment_size", want.segment_size, out_beat_o.segment_size);
        check_field("segment_index", want.segment_index, out_beat_o.segment_index);
        check_field("segment_valid", want.segment_valid, out_beat_o.segment_valid);
        check_field("end_of_name", want.end_of_name, out_beat_o.end_of_name);
        check_field("segment_count", want.segment_count, out_beat_o.segment_count);
        check_field("parse_status", want.parse_status, out_beat_o.parse_status);
      end
    end
  end

  initial begin
    restart_name();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_byte_bound();
    test_output_hold();
    test_random_names();
    in_valid_i <= 1'b0;
    for (int i = 0; i < 20000 && pending_reports.size() != 0; i++) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);
    if (pending_reports.size() != 0) begin
      $error("%0d expected output beats never arrived", pending_reports.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tlv_name_segment_indexer_top: match");
    end else begin
      $display("tlv_name_segment_indexer_top: mismatch");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("tlv_name_segment_indexer_top: mismatch");
    $finish;
  end

endmodule
